// File: rtl/qe_pkg.sv
// ---------------------------------------------------------------------------
// qe_pkg: shared types and constants for the quaternion to Euler converter
// Fixed-point formats, pipeline payload structs, arctangent table and the
// binary-angle to degrees*128 conversion.
// ---------------------------------------------------------------------------
package qe_pkg;

    localparam int VEC_W       = 37;   // CORDIC x/y datapath
    localparam int ACC_W       = 34;   // CORDIC angle accumulator
    localparam int SQRT_W      = 62;   // square root remainder/root
    localparam int SQRT_STEPS  = 31;   // one root bit per stage
    localparam int NUM_LANES   = 3;
    localparam int LANE_YAW    = 0;
    localparam int LANE_ROLL   = 1;
    localparam int LANE_PITCH  = 2;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [32:0]      angle_t;   // binary angle, 2^32 per turn
    typedef logic signed [31:0]      q30_t;
    typedef logic [1:0]              pole_t;

    localparam pole_t POLE_NONE = 2'd0;
    localparam pole_t POLE_NEG  = 2'd1;
    localparam pole_t POLE_POS  = 2'd2;

    localparam logic signed [32:0] POLE_LIMIT = 33'sd536870375;
    localparam logic signed [33:0] ONE_Q30    = 34'sd1073741824;
    localparam acc_t               HALF_TURN  = 34'sd2147483648;
    localparam logic [SQRT_W-1:0]  ONE_Q60    = 62'd1 << 60;
    localparam logic signed [16:0] DEG_HALF   = 17'sd23040;
    localparam logic signed [16:0] DEG_TURN   = 17'sd46080;
    localparam logic signed [14:0] DEG_QUARTER = 15'sd11520;

    // payload carried alongside the square root
    typedef struct packed {
        vec_t  yaw_y;
        vec_t  yaw_x;
        vec_t  roll_y;
        vec_t  roll_x;
        q30_t  s;
        pole_t pole;
    } work_t;

    typedef struct packed {
        pole_t                pole;
        logic signed [15:0]   yaw;
        logic signed [14:0]   pitch;
        logic signed [15:0]   roll;
    } result_t;

    function automatic logic [29:0] atan_entry(input int idx);
        logic [29:0] v;
        unique case (idx)
            0:  v = 30'h20000000;
            1:  v = 30'h12E4051E;
            2:  v = 30'h09FB385B;
            3:  v = 30'h051111D4;
            4:  v = 30'h028B0D43;
            5:  v = 30'h0145D7E1;
            6:  v = 30'h00A2F61E;
            7:  v = 30'h00517C55;
            8:  v = 30'h0028BE53;
            9:  v = 30'h00145F2F;
            10: v = 30'h000A2F98;
            11: v = 30'h000517CC;
            12: v = 30'h00028BE6;
            13: v = 30'h000145F3;
            14: v = 30'h0000A2FA;
            15: v = 30'h0000517D;
            16: v = 30'h000028BE;
            17: v = 30'h0000145F;
            18: v = 30'h00000A30;
            19: v = 30'h00000518;
            20: v = 30'h0000028C;
            21: v = 30'h00000146;
            22: v = 30'h000000A3;
            23: v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    // round(a * 45 / 2^22), half up
    function automatic logic signed [15:0] to_deg128(input angle_t a);
        logic signed [39:0] t;
        t = 40'(a) * 40'sd45 + 40'sd2097152;
        return 16'(t >>> 22);
    endfunction

endpackage

// File: rtl/quaternion_to_euler_angles.sv
// ---------------------------------------------------------------------------
// quaternion_to_euler_angles: unit quaternion to ZYX roll, pitch and yaw
// Fully pipelined fixed-point converter with CORDIC arctangents.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one item is a quaternion x, y, z, w, each signed
//   Q1.15 (COMPONENT_WIDTH bits, one integer bit). Result stream m_*: roll,
//   pitch and yaw in degrees*128 on m_tdata, the pole code on m_tuser
//   (0 none, 1 negative pole, 2 positive pole).
//   Throughput: one item per cycle while the skid slot is empty.
//   Pipeline: three front stages, a 32-stage square root (set-up plus one
//   stage per root bit) feeding the pitch arctangent, CORDIC_STAGES + 1
//   CORDIC stages, two finishing stages and the output register.
//   Stalls: the whole pipeline advances together. An output register plus
//   one skid slot: a result that arrives while the output is held parks in
//   the skid slot, and the pipeline and s_tready hold while it is occupied,
//   so s_tready follows m_tready through the registered skid slot.
//   Reset: aresetn low clears all valid bits, the output and skid slot; no
//   clearing pass, the block accepts items as soon as reset is released.
//   No configuration registers.
// ---------------------------------------------------------------------------
module quaternion_to_euler_angles import qe_pkg::*; #(
    parameter int CORDIC_STAGES   = 16,
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             s_tvalid,
    output logic                                             s_tready,
    // quat_x, quat_y, quat_z, quat_w from the lowest bit up
    input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]            s_tdata,
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    // roll_deg[15:0], pitch_deg[30:16], yaw_deg[46:31], zero pad
    output logic [47:0]                                      m_tdata,
    // pole_hit[1:0]
    output logic [1:0]                                       m_tuser
);

    localparam int CW = COMPONENT_WIDTH;

    logic en;                     // pipeline advance
    logic push;

    logic              f_valid;
    logic [SQRT_W-1:0] f_sq;
    work_t             f_work;

    logic              q_valid;
    logic [30:0]       q_root;
    work_t             q_work;

    vec_t   c_y [NUM_LANES];
    vec_t   c_x [NUM_LANES];
    logic   c_valid;
    angle_t c_ang [NUM_LANES];
    pole_t  c_pole;

    logic    t_valid;
    result_t t_res;

    logic    m_valid_reg;
    result_t m_res_reg;
    logic    skid_valid_reg;
    result_t skid_res_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    qe_front #(
        .COMPONENT_WIDTH (CW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_x      (s_tdata[CW-1:0]),
        .in_y      (s_tdata[2*CW-1:CW]),
        .in_z      (s_tdata[3*CW-1:2*CW]),
        .in_w      (s_tdata[4*CW-1:3*CW]),
        .out_valid (f_valid),
        .out_sq    (f_sq),
        .out_work  (f_work)
    );

    // cos(pitch) = sqrt(1 - sin^2), Q.30
    qe_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_sq     (f_sq),
        .in_work   (f_work),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_work  (q_work)
    );

    always_comb begin
        c_y[LANE_YAW]   = q_work.yaw_y;
        c_x[LANE_YAW]   = q_work.yaw_x;
        c_y[LANE_ROLL]  = q_work.roll_y;
        c_x[LANE_ROLL]  = q_work.roll_x;
        c_y[LANE_PITCH] = VEC_W'(q_work.s);
        c_x[LANE_PITCH] = VEC_W'(q_root);
    end

    qe_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_y      (c_y),
        .in_x      (c_x),
        .in_pole   (q_work.pole),
        .out_valid (c_valid),
        .out_ang   (c_ang),
        .out_pole  (c_pole)
    );

    qe_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid),
        .in_ang    (c_ang),
        .in_pole   (c_pole),
        .out_valid (t_valid),
        .out_res   (t_res)
    );

    // output register with one skid slot
    assign push = en && t_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_res_reg      <= skid_res_reg;
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                m_res_reg   <= t_res;
                m_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end else if (push) begin
            skid_res_reg   <= t_res;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.yaw, m_res_reg.pitch, m_res_reg.roll};
    assign m_tuser  = m_res_reg.pole;

    // skid slot only fills behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid slot holds an item with no output pending");

    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid slot filled while output was free");

    a_pole_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_res_reg.pole != POLE_NONE) |->
        (m_res_reg.pitch == DEG_QUARTER || m_res_reg.pitch == -DEG_QUARTER))
        else $error("pole item without +/-90 degree pitch");

    a_pole_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_res_reg.pole == POLE_NONE || m_res_reg.pole == POLE_NEG ||
                         m_res_reg.pole == POLE_POS))
        else $error("undefined pole code on output");

endmodule

// File: rtl/qe_front.sv
// ---------------------------------------------------------------------------
// qe_front: component products, angle operands and pitch sine squared
// Three register stages: products, sums and pole test, square of the sine.
// ---------------------------------------------------------------------------
module qe_front import qe_pkg::*; #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [COMPONENT_WIDTH-1:0] in_x,
    input  logic signed [COMPONENT_WIDTH-1:0] in_y,
    input  logic signed [COMPONENT_WIDTH-1:0] in_z,
    input  logic signed [COMPONENT_WIDTH-1:0] in_w,
    output logic                              out_valid,
    output logic [SQRT_W-1:0]                 out_sq,
    output work_t                             out_work
);

    localparam int PROD_W = 2 * COMPONENT_WIDTH;
    localparam int SHR    = (PROD_W >= 32) ? PROD_W - 32 : 0;
    localparam int SHL    = (PROD_W < 32) ? 32 - PROD_W : 0;

    function automatic q30_t mul30(input logic signed [COMPONENT_WIDTH-1:0] a,
                                   input logic signed [COMPONENT_WIDTH-1:0] b);
        logic signed [PROD_W-1:0] p;
        logic signed [63:0]       e;
        p = PROD_W'(a) * PROD_W'(b);
        e = 64'(p);
        return 32'((e >>> SHR) <<< SHL);
    endfunction

    // stage 1
    logic [2:0] v_reg;
    q30_t xx_reg, yy_reg, zz_reg, zx_reg, wy_reg, wz_reg, xy_reg, wx_reg, yz_reg;
    vec_t x_raw_reg, w_raw_reg;

    // stage 2
    logic signed [32:0] test;
    logic signed [33:0] s2;
    work_t              work_next;
    work_t              work2_reg;

    // stage 3
    logic [30:0]        s_mag;
    work_t              work3_reg;
    logic [SQRT_W-1:0]  sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg    <= mul30(in_x, in_x);
            yy_reg    <= mul30(in_y, in_y);
            zz_reg    <= mul30(in_z, in_z);
            zx_reg    <= mul30(in_z, in_x);
            wy_reg    <= mul30(in_w, in_y);
            wz_reg    <= mul30(in_w, in_z);
            xy_reg    <= mul30(in_x, in_y);
            wx_reg    <= mul30(in_w, in_x);
            yz_reg    <= mul30(in_y, in_z);
            x_raw_reg <= VEC_W'(in_x);
            w_raw_reg <= VEC_W'(in_w);
        end
    end

    always_comb begin
        test = 33'(zx_reg) - 33'(wy_reg);
        s2   = 34'(test) <<< 1;
        work_next.yaw_y = (VEC_W'(wz_reg) + VEC_W'(xy_reg)) <<< 1;
        work_next.yaw_x = VEC_W'(ONE_Q30) - ((VEC_W'(yy_reg) + VEC_W'(zz_reg)) <<< 1);
        if (test < -POLE_LIMIT) begin
            work_next.pole = POLE_NEG;
        end else if (test > POLE_LIMIT) begin
            work_next.pole = POLE_POS;
        end else begin
            work_next.pole = POLE_NONE;
        end
        // at a pole the roll lane measures atan2(x, w) instead
        if (work_next.pole != POLE_NONE) begin
            work_next.roll_y = x_raw_reg;
            work_next.roll_x = w_raw_reg;
        end else begin
            work_next.roll_y = -((VEC_W'(wx_reg) + VEC_W'(yz_reg)) <<< 1);
            work_next.roll_x = VEC_W'(ONE_Q30) -
                               ((VEC_W'(xx_reg) + VEC_W'(yy_reg)) <<< 1);
        end
        if (s2 > ONE_Q30) begin
            work_next.s = 32'(ONE_Q30);
        end else if (s2 < -ONE_Q30) begin
            work_next.s = 32'(-ONE_Q30);
        end else begin
            work_next.s = 32'(s2);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work2_reg <= work_next;
        end
    end

    assign s_mag = work2_reg.s[31] ? 31'(-work2_reg.s) : 31'(work2_reg.s);

    always_ff @(posedge aclk) begin
        if (en) begin
            work3_reg <= work2_reg;
            sq_reg    <= SQRT_W'(s_mag) * SQRT_W'(s_mag);
        end
    end

    assign out_valid = v_reg[2];
    assign out_sq    = sq_reg;
    assign out_work  = work3_reg;

endmodule

// File: rtl/qe_isqrt.sv
// ---------------------------------------------------------------------------
// qe_isqrt: pipelined integer square root of 2^60 - s^2
// Restoring digit method, one root bit per stage, payload carried along.
// ---------------------------------------------------------------------------
module qe_isqrt import qe_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQRT_W-1:0] in_sq,
    input  work_t             in_work,
    output logic              out_valid,
    output logic [30:0]       out_root,
    output work_t             out_work
);

    logic [SQRT_STEPS:0] v_reg;
    logic [SQRT_W-1:0]   rem_reg  [0:SQRT_STEPS];
    logic [SQRT_W-1:0]   root_reg [0:SQRT_STEPS];
    work_t               work_reg [0:SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[SQRT_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= ONE_Q60 - in_sq;
            root_reg[0] <= '0;
            work_reg[0] <= in_work;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [SQRT_W-1:0] trial;
        assign trial = root_reg[k] + BIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                work_reg[k+1] <= work_reg[k];
                if (rem_reg[k] >= trial) begin
                    rem_reg[k+1]  <= rem_reg[k] - trial;
                    root_reg[k+1] <= (root_reg[k] >> 1) + BIT;
                end else begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k] >> 1;
                end
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS];
    assign out_root  = root_reg[SQRT_STEPS][30:0];
    assign out_work  = work_reg[SQRT_STEPS];

endmodule

// File: rtl/qe_cordic.sv
// ---------------------------------------------------------------------------
// qe_cordic: pipelined vectoring CORDIC, three lanes in lockstep
// Quadrant fold, one micro-rotation per stage, clamp to half a turn.
// ---------------------------------------------------------------------------
module qe_cordic import qe_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  vec_t   in_y [NUM_LANES],
    input  vec_t   in_x [NUM_LANES],
    input  pole_t  in_pole,
    output logic   out_valid,
    output angle_t out_ang [NUM_LANES],
    output pole_t  out_pole
);

    logic [STAGES:0] v_reg;
    vec_t  x_reg    [0:STAGES][NUM_LANES];
    vec_t  y_reg    [0:STAGES][NUM_LANES];
    acc_t  z_reg    [0:STAGES][NUM_LANES];
    logic  zero_reg [0:STAGES][NUM_LANES];
    pole_t pole_reg [0:STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[STAGES-1:0], in_valid};
        end
    end

    // left half-plane folded onto the right
    always_ff @(posedge aclk) begin
        if (en) begin
            pole_reg[0] <= in_pole;
            for (int l = 0; l < NUM_LANES; l++) begin
                zero_reg[0][l] <= (in_x[l] == '0) && (in_y[l] == '0);
                if (in_x[l] < 0) begin
                    z_reg[0][l] <= (in_y[l] >= 0) ? HALF_TURN : -HALF_TURN;
                    x_reg[0][l] <= -in_x[l];
                    y_reg[0][l] <= -in_y[l];
                end else begin
                    z_reg[0][l] <= '0;
                    x_reg[0][l] <= in_x[l];
                    y_reg[0][l] <= in_y[l];
                end
            end
        end
    end

    for (genvar i = 1; i <= STAGES; i++) begin : g_stage
        localparam acc_t STEP = ACC_W'(atan_entry(i - 1));
        always_ff @(posedge aclk) begin
            if (en) begin
                pole_reg[i] <= pole_reg[i-1];
                for (int l = 0; l < NUM_LANES; l++) begin
                    zero_reg[i][l] <= zero_reg[i-1][l];
                    if (y_reg[i-1][l] > 0) begin
                        x_reg[i][l] <= x_reg[i-1][l] + (y_reg[i-1][l] >>> (i - 1));
                        y_reg[i][l] <= y_reg[i-1][l] - (x_reg[i-1][l] >>> (i - 1));
                        z_reg[i][l] <= z_reg[i-1][l] + STEP;
                    end else begin
                        x_reg[i][l] <= x_reg[i-1][l] - (y_reg[i-1][l] >>> (i - 1));
                        y_reg[i][l] <= y_reg[i-1][l] + (x_reg[i-1][l] >>> (i - 1));
                        z_reg[i][l] <= z_reg[i-1][l] - STEP;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (zero_reg[STAGES][l]) begin
                out_ang[l] = '0;
            end else if (z_reg[STAGES][l] > HALF_TURN) begin
                out_ang[l] = 33'(HALF_TURN);
            end else if (z_reg[STAGES][l] < -HALF_TURN) begin
                out_ang[l] = 33'(-HALF_TURN);
            end else begin
                out_ang[l] = 33'(z_reg[STAGES][l]);
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_pole  = pole_reg[STAGES];

endmodule

// File: rtl/qe_finish.sv
// ---------------------------------------------------------------------------
// qe_finish: pole roll combination and conversion to degrees*128
// Two register stages: roll angle wrap, then scaling and pole overrides.
// ---------------------------------------------------------------------------
module qe_finish import qe_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    in_valid,
    input  angle_t  in_ang [NUM_LANES],
    input  pole_t   in_pole,
    output logic    out_valid,
    output result_t out_res
);

    logic [1:0]         v_reg;
    logic signed [34:0] roll_raw;
    angle_t             roll_bin;
    angle_t             yaw_reg, roll_reg, pitch_reg;
    pole_t              pole_reg;
    logic signed [16:0] roll_d;
    result_t            res_next;
    result_t            res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    // pole: roll = (+/-yaw) - 2*atan2(x, w), taken modulo one turn
    always_comb begin
        if (in_pole == POLE_NEG) begin
            roll_raw = -35'(in_ang[LANE_YAW]) - (35'(in_ang[LANE_ROLL]) <<< 1);
        end else begin
            roll_raw = 35'(in_ang[LANE_YAW]) - (35'(in_ang[LANE_ROLL]) <<< 1);
        end
        if (in_pole != POLE_NONE) begin
            roll_bin = 33'($signed(roll_raw[31:0]));
        end else begin
            roll_bin = in_ang[LANE_ROLL];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            yaw_reg   <= in_ang[LANE_YAW];
            roll_reg  <= roll_bin;
            pitch_reg <= in_ang[LANE_PITCH];
            pole_reg  <= in_pole;
        end
    end

    always_comb begin
        roll_d        = 17'(to_deg128(roll_reg));
        res_next.yaw  = to_deg128(yaw_reg);
        res_next.pole = pole_reg;
        unique case (pole_reg)
            POLE_NEG: res_next.pitch = -DEG_QUARTER;
            POLE_POS: res_next.pitch = DEG_QUARTER;
            default:  res_next.pitch = 15'(to_deg128(pitch_reg));
        endcase
        // a wrapped pole roll of -180 is reported as +180
        if (pole_reg != POLE_NONE && roll_d <= -DEG_HALF) begin
            res_next.roll = 16'(roll_d + DEG_TURN);
        end else begin
            res_next.roll = 16'(roll_d);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg[1];
    assign out_res   = res_reg;

endmodule
